### design/sm3_pkg.sv
package sm3_pkg;

   typedef struct packed {
      logic [7:0] msg_byte;
      logic       byte_present;
      logic       end_of_message;
   } req_type;

   typedef struct packed {
      logic [31:0] digest_word;
      logic [2:0]  word_index;
      logic        last_word;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CHECK,
      ST_RUN,
      ST_PAD,
      ST_SPLIT,
      ST_RUN_EXTRA,
      ST_LENGTH,
      ST_START,
      ST_RUN_LAST,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic absorb;
      logic start_compress;
      logic pad_first;
      logic pad_length;
      logic emit_next;
      logic reset_chain;
   } cmd_type;

   typedef struct packed {
      logic       compress_busy;
      logic       block_full;
      logic       block_last;
      logic       needs_extra;
      logic [2:0] emit_index;
   } status_type;

   localparam logic [255:0] SM3_IV = {
      32'h7380166f, 32'h4914b2b9, 32'h172442d7, 32'hda8a0600,
      32'ha96f30bc, 32'h163138aa, 32'he38dee4d, 32'hb0fb0e4e
   };
   localparam logic [31:0] T_LOW  = 32'h79cc4519;
   localparam logic [31:0] T_HIGH = 32'h7a879d8a;
   localparam logic [7:0]  PAD_BYTE = 8'h80;
   localparam int unsigned LEN_OFFSET = 56;

   function automatic logic [31:0] rotl(input logic [31:0] x, input logic [4:0] n);
      logic [63:0] d;
      d = {x, x} << n;
      return d[63:32];
   endfunction

   function automatic logic [31:0] perm0(input logic [31:0] x);
      return x ^ rotl(x, 5'd9) ^ rotl(x, 5'd17);
   endfunction

   function automatic logic [31:0] perm1(input logic [31:0] x);
      return x ^ rotl(x, 5'd15) ^ rotl(x, 5'd23);
   endfunction

endpackage

### design/sm3_datapath.sv
module sm3_datapath (
   input  logic               clock,
   input  logic               reset,
   input  sm3_pkg::req_type   req_payload,
   input  sm3_pkg::cmd_type   cmd,
   output sm3_pkg::status_type status,
   output sm3_pkg::rsp_type   rsp_payload
);
   import sm3_pkg::*;

   logic [31:0]  block_ff [16];
   logic [6:0]   fill_ff, fill_in;
   logic [60:0]  count_ff, count_in;
   logic [255:0] chain_ff, chain_in;
   logic [31:0]  w_ff [16];
   logic [255:0] work_ff, work_in;
   logic [5:0]   round_ff, round_in;
   logic         busy_ff, busy_in;
   logic [2:0]   emit_ff, emit_in;

   logic [31:0] a, b, c, d, e, f, g, h;
   logic [31:0] tj, a12, ss1, ss2, ff_v, gg_v, tt1, tt2, w_new;
   logic [5:0]  pos;
   logic [63:0] bits;

   assign pos  = fill_ff[5:0];
   assign bits = {count_ff, 3'b000};

   always_comb begin
      {a, b, c, d, e, f, g, h} = work_ff;
      tj   = (round_ff < 6'd16) ? T_LOW : T_HIGH;
      a12  = rotl(a, 5'd12);
      ss1  = rotl(a12 + e + rotl(tj, round_ff[4:0]), 5'd7);
      ss2  = ss1 ^ a12;
      if (round_ff < 6'd16) begin
         ff_v = a ^ b ^ c;
         gg_v = e ^ f ^ g;
      end else begin
         ff_v = (a & b) | (a & c) | (b & c);
         gg_v = (e & f) | (~e & g);
      end
      tt1   = ff_v + d + ss2 + (w_ff[0] ^ w_ff[4]);
      tt2   = gg_v + h + ss1 + w_ff[0];
      w_new = perm1(w_ff[0] ^ w_ff[7] ^ rotl(w_ff[13], 5'd15))
              ^ rotl(w_ff[3], 5'd7) ^ w_ff[10];
   end

   always_comb begin
      fill_in  = fill_ff;
      count_in = count_ff;
      chain_in = chain_ff;
      work_in  = work_ff;
      round_in = round_ff;
      busy_in  = busy_ff;
      emit_in  = emit_ff;
      if (cmd.absorb && req_payload.byte_present) begin
         fill_in  = fill_ff + 7'd1;
         count_in = count_ff + 61'd1;
      end
      if (cmd.start_compress) begin
         work_in  = chain_ff;
         round_in = '0;
         busy_in  = 1'b1;
         fill_in  = '0;
      end else if (busy_ff) begin
         work_in  = {tt1, a, rotl(b, 5'd9), c, perm0(tt2), e, rotl(f, 5'd19), g};
         round_in = round_ff + 6'd1;
         if (round_ff == 6'd63) begin
            busy_in  = 1'b0;
            chain_in = chain_ff ^ work_in;
         end
      end
      if (cmd.emit_next) begin
         emit_in = emit_ff + 3'd1;
      end
      if (cmd.reset_chain) begin
         chain_in = SM3_IV;
         fill_in  = '0;
         count_in = '0;
         emit_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff  <= '0;
         count_ff <= '0;
         chain_ff <= SM3_IV;
         busy_ff  <= 1'b0;
         emit_ff  <= '0;
      end else begin
         fill_ff  <= fill_in;
         count_ff <= count_in;
         chain_ff <= chain_in;
         busy_ff  <= busy_in;
         emit_ff  <= emit_in;
      end
      work_ff  <= work_in;
      round_ff <= round_in;
   end

   always_ff @(posedge clock) begin
      if (cmd.absorb && req_payload.byte_present) begin
         block_ff[pos[5:2]][{~pos[1:0], 3'b000} +: 8] <= req_payload.msg_byte;
      end
      if (cmd.pad_first) begin
         for (int j = 0; j < 16; j++) begin
            for (int k = 0; k < 4; k++) begin
               if (4 * j + k == int'(pos)) begin
                  block_ff[j][8 * (3 - k) +: 8] <= PAD_BYTE;
               end else if (4 * j + k > int'(pos)) begin
                  block_ff[j][8 * (3 - k) +: 8] <= 8'h00;
               end
            end
         end
      end
      if (cmd.pad_length) begin
         block_ff[14] <= bits[63:32];
         block_ff[15] <= bits[31:0];
         if (extra_ff) begin
            for (int j = 0; j < 14; j++) begin
               block_ff[j] <= 32'h0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start_compress) begin
         for (int j = 0; j < 16; j++) begin
            w_ff[j] <= block_ff[j];
         end
      end else if (busy_ff) begin
         for (int j = 0; j < 15; j++) begin
            w_ff[j] <= w_ff[j + 1];
         end
         w_ff[15] <= w_new;
      end
   end

   logic extra_ff, extra_in;
   assign extra_in = cmd.pad_first ? (pos >= 6'(LEN_OFFSET)) : extra_ff;
   always_ff @(posedge clock) begin
      extra_ff <= extra_in;
   end

   assign status.compress_busy = busy_ff;
   assign status.block_full    = (fill_ff == 7'd64);
   assign status.block_last    = (fill_ff == 7'd63);
   assign status.needs_extra   = extra_ff;
   assign status.emit_index    = emit_ff;

   assign rsp_payload.digest_word = chain_ff[32 * (7 - int'(emit_ff)) +: 32];
   assign rsp_payload.word_index  = emit_ff;
   assign rsp_payload.last_word   = (emit_ff == 3'd7);

endmodule

### design/sm3_control.sv
module sm3_control (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  sm3_pkg::req_type    req_payload,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   input  sm3_pkg::status_type status,
   output sm3_pkg::cmd_type    cmd
);
   import sm3_pkg::*;

   state_type state_ff, state_in;
   logic      end_ff, end_in;
   logic      accept;

   assign accept = req_valid && (state_ff == ST_IDLE);
   assign end_in = accept ? req_payload.end_of_message : end_ff;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if ((req_payload.byte_present && status.block_last) ||
                   req_payload.end_of_message) begin
                  state_in = ST_CHECK;
               end
            end
         end
         ST_CHECK: begin
            if (status.block_full) begin
               state_in = ST_RUN;
            end else if (end_ff) begin
               state_in = ST_PAD;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_RUN: begin
            if (!status.compress_busy) begin
               state_in = end_ff ? ST_PAD : ST_IDLE;
            end
         end
         ST_PAD: begin
            state_in = ST_SPLIT;
         end
         ST_SPLIT: begin
            state_in = status.needs_extra ? ST_RUN_EXTRA : ST_LENGTH;
         end
         ST_RUN_EXTRA: begin
            if (!status.compress_busy) begin
               state_in = ST_LENGTH;
            end
         end
         ST_LENGTH: begin
            state_in = ST_START;
         end
         ST_START: begin
            state_in = ST_RUN_LAST;
         end
         ST_RUN_LAST: begin
            if (!status.compress_busy) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (!rsp_stall && status.emit_index == 3'd7) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      rsp_valid = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall  = 1'b0;
            cmd.absorb = req_valid;
         end
         ST_CHECK: begin
            cmd.start_compress = status.block_full;
         end
         ST_PAD: begin
            cmd.pad_first = 1'b1;
         end
         ST_SPLIT: begin
            cmd.start_compress = status.needs_extra;
         end
         ST_LENGTH: begin
            cmd.pad_length = 1'b1;
         end
         ST_START: begin
            cmd.start_compress = 1'b1;
         end
         ST_EMIT: begin
            rsp_valid       = 1'b1;
            cmd.emit_next   = !rsp_stall;
            cmd.reset_chain = !rsp_stall && status.emit_index == 3'd7;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         end_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         end_ff   <= end_in;
      end
   end

endmodule

### design/sm3_stream_hasher_unit.sv
// SM3 byte-stream hasher. At most one message byte is taken per beat, and
// every 64th byte starts a compression of 64 rounds at one round per cycle,
// during which further input is stalled. An end beat adds padding and one or
// two more compressions, then the digest leaves as eight beats, most
// significant word first, after which the chaining value returns to the
// initial vector.
module sm3_stream_hasher_unit (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  sm3_pkg::req_type req_payload,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output sm3_pkg::rsp_type rsp_payload
);
   import sm3_pkg::*;

   cmd_type    cmd;
   status_type status;

   sm3_control u_control (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .status      (status),
      .cmd         (cmd)
   );

   sm3_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .cmd         (cmd),
      .status      (status),
      .rsp_payload (rsp_payload)
   );

endmodule

### design/sm3_checker.sv
module sm3_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_stall,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input sm3_pkg::rsp_type rsp_payload
);
   import sm3_pkg::*;

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_payload))
      else $error("stalled beat changed");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("input taken during digest output");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_payload.last_word |=> rsp_valid)
      else $error("digest burst broken");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_payload.last_word == (rsp_payload.word_index == 3'd7))
      else $error("last word flag mismatch");

endmodule

bind sm3_stream_hasher_unit sm3_checker u_checker (.*);

### sim/sm3_stream_hasher_unit_test.sv
`timescale 1ns / 100ps

class sm3_digest_board;
   bit [31:0] chain [8];
   bit [7:0]  block_bytes [64];
   int        fill;
   bit [60:0] byte_total;
   sm3_pkg::rsp_type pending [$];
   int        errors;

   function new();
      errors = 0;
      restart();
   endfunction

   function void restart();
      for (int i = 0; i < 8; i++) chain[i] = sm3_pkg::SM3_IV[255 - 32 * i -: 32];
      for (int i = 0; i < 64; i++) block_bytes[i] = 8'h00;
      fill = 0;
      byte_total = '0;
   endfunction

   function bit [31:0] rol(bit [31:0] x, int n);
      n = n % 32;
      if (n == 0) return x;
      return (x << n) | (x >> (32 - n));
   endfunction

   function bit [31:0] p0(bit [31:0] x);
      return x ^ rol(x, 9) ^ rol(x, 17);
   endfunction

   function bit [31:0] p1(bit [31:0] x);
      return x ^ rol(x, 15) ^ rol(x, 23);
   endfunction

   function void compress();
      bit [31:0] w [68];
      bit [31:0] a, b, c, d, e, f, g, h, t, a12, ss1, ss2, ff, gg, tt1, tt2;
      for (int j = 0; j < 16; j++)
         w[j] = {block_bytes[4*j], block_bytes[4*j+1], block_bytes[4*j+2],
                 block_bytes[4*j+3]};
      for (int j = 16; j < 68; j++)
         w[j] = p1(w[j-16] ^ w[j-9] ^ rol(w[j-3], 15)) ^ rol(w[j-13], 7) ^ w[j-6];
      a = chain[0]; b = chain[1]; c = chain[2]; d = chain[3];
      e = chain[4]; f = chain[5]; g = chain[6]; h = chain[7];
      for (int j = 0; j < 64; j++) begin
         t = (j < 16) ? sm3_pkg::T_LOW : sm3_pkg::T_HIGH;
         a12 = rol(a, 12);
         ss1 = rol(a12 + e + rol(t, j), 7);
         ss2 = ss1 ^ a12;
         if (j < 16) begin
            ff = a ^ b ^ c;
            gg = e ^ f ^ g;
         end else begin
            ff = (a & b) | (a & c) | (b & c);
            gg = (e & f) | (~e & g);
         end
         tt1 = ff + d + ss2 + (w[j] ^ w[j+4]);
         tt2 = gg + h + ss1 + w[j];
         d = c; c = rol(b, 9); b = a; a = tt1;
         h = g; g = rol(f, 19); f = e; e = p0(tt2);
      end
      chain[0] ^= a; chain[1] ^= b; chain[2] ^= c; chain[3] ^= d;
      chain[4] ^= e; chain[5] ^= f; chain[6] ^= g; chain[7] ^= h;
   endfunction

   function void note_input(sm3_pkg::req_type beat);
      bit [63:0] bits;
      sm3_pkg::rsp_type r;
      if (beat.byte_present) begin
         block_bytes[fill] = beat.msg_byte;
         fill++;
         byte_total++;
         if (fill == 64) begin
            compress();
            fill = 0;
         end
      end
      if (!beat.end_of_message) return;
      block_bytes[fill] = sm3_pkg::PAD_BYTE;
      for (int i = fill + 1; i < 64; i++) block_bytes[i] = 8'h00;
      if (fill + 1 > sm3_pkg::LEN_OFFSET) begin
         compress();
         for (int i = 0; i < 64; i++) block_bytes[i] = 8'h00;
      end
      bits = {byte_total, 3'b000};
      for (int i = 0; i < 8; i++) block_bytes[63 - i] = bits[8*i +: 8];
      compress();
      for (int i = 0; i < 8; i++) begin
         r.digest_word = chain[i];
         r.word_index = 3'(i);
         r.last_word = (i == 7);
         pending.push_back(r);
      end
      restart();
   endfunction

   function void report(string what);
      $display("mismatch: %s", what);
      errors++;
   endfunction

   function void check_result(sm3_pkg::rsp_type got);
      sm3_pkg::rsp_type want;
      if (pending.size() == 0) begin
         report($sformatf("unexpected word %h", got.digest_word));
         return;
      end
      want = pending.pop_front();
      if (got.digest_word != want.digest_word)
         report($sformatf("digest_word %h, want %h", got.digest_word, want.digest_word));
      if (got.word_index != want.word_index)
         report($sformatf("word_index %0d, want %0d", got.word_index, want.word_index));
      if (got.last_word != want.last_word)
         report($sformatf("last_word %b, want %b", got.last_word, want.last_word));
   endfunction
endclass

module sm3_stream_hasher_unit_test;
   import sm3_pkg::*;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_payload;
   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp_payload;

   sm3_digest_board board;
   int  idle_percent;
   int  items_sent;
   bit  hold_receiver;
   bit  stimulus_done;

   sm3_stream_hasher_unit dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_payload(req_payload),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_payload(rsp_payload)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   task automatic send_beat(logic [7:0] value, logic present, logic last);
      while (idle_percent > 0 && $urandom_range(99, 0) < idle_percent) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_payload <= '{msg_byte: value, byte_present: present, end_of_message: last};
      @(posedge clock);
      while (req_stall) @(posedge clock);
      board.note_input('{msg_byte: value, byte_present: present, end_of_message: last});
      items_sent++;
   endtask

   task automatic send_message(int length);
      for (int i = 0; i < length; i++) begin
         if ($urandom_range(9, 0) == 0) send_beat(8'($urandom), 1'b0, 1'b0);
         if (i == length - 1 && $urandom_range(1, 0)) begin
            send_beat(8'($urandom), 1'b1, 1'b1);
            return;
         end
         send_beat(8'($urandom), 1'b1, 1'b0);
      end
      send_beat(8'($urandom), 1'b0, 1'b1);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= hold_receiver ||
                      (idle_percent > 0 && $urandom_range(99, 0) < idle_percent);
         if (rsp_valid && !rsp_stall) board.check_result(rsp_payload);
      end
   end

   initial begin
      int lens [$];
      board = new();
      idle_percent = 35;
      items_sent = 0;
      hold_receiver = 1'b0;
      stimulus_done = 1'b0;
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_payload <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_beat(8'h00, 1'b0, 1'b1);
      send_beat(8'h00, 1'b0, 1'b0);
      send_beat(8'hff, 1'b1, 1'b1);
      send_beat(8'h00, 1'b1, 1'b0);
      send_beat(8'h61, 1'b1, 1'b0);
      send_beat(8'h62, 1'b1, 1'b1);
      send_beat(8'haa, 1'b1, 1'b0);
      send_beat(8'h55, 1'b1, 1'b0);
      send_beat(8'h00, 1'b0, 1'b1);

      lens = '{55, 56, 63, 64, 65};
      foreach (lens[k]) begin
         if (k == 3) idle_percent = 0;
         send_message(lens[k]);
      end
      idle_percent = 35;

      fork
         begin
            hold_receiver = 1'b1;
            repeat (400) @(posedge clock);
            hold_receiver = 1'b0;
         end
         repeat (3) send_message($urandom_range(3, 0));
      join

      while (items_sent < 460) begin
         send_message($urandom_range(12, 0));
      end
      req_valid <= 1'b0;
      stimulus_done = 1'b1;
   end

   initial begin
      wait (stimulus_done);
      while (board.pending.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (board.errors == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

   initial begin
      #3000000;
      $display("CHECKS FAILED");
      $finish;
   end
endmodule
